[rtl/bcwp_pkg.sv]
// Shared types, constants and arithmetic helpers for the bone collider world position unit.
// No dependencies; every other file but bcwp_checker refers to this package by scoped names.
package bcwp_pkg;

   localparam int MAX_FRAMES = 64;
   localparam int MAX_JOINTS = 32;
   localparam int MAX_BONES  = 16;

   localparam int FRAME_W = $clog2(MAX_FRAMES);
   localparam int JOINT_W = $clog2(MAX_JOINTS);
   localparam int BONE_W  = $clog2(MAX_BONES);
   localparam int POSE_W  = FRAME_W + JOINT_W;
   localparam int POSE_SLOTS = MAX_FRAMES * MAX_JOINTS;

   localparam int LANES   = 7;          // 3 position words then 4 quaternion words
   localparam int FRAC_W  = 12;
   localparam logic [31:0] ONE_FX = 32'h0000_1000;

   typedef enum logic [1:0] {
      OP_LOAD_POS  = 2'd0,
      OP_LOAD_ORI  = 2'd1,
      OP_LOAD_BONE = 2'd2,
      OP_QUERY     = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CSR_FRAME_COUNT = 3'd0,
      CSR_JOINT_COUNT = 3'd1,
      CSR_MODEL_X     = 3'd2,
      CSR_MODEL_Y     = 3'd3,
      CSR_MODEL_Z     = 3'd4,
      CSR_SCALE_X     = 3'd5,
      CSR_SCALE_Y     = 3'd6,
      CSR_SCALE_Z     = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic [6:0]  frame_count;
      logic [5:0]  joint_count;
      logic [2:0][31:0] model;
      logic [2:0][31:0] scale;
   } cfg_type;

   // One query as handed from front to back.
   typedef struct packed {
      logic              found;
      logic [1:0]        kind;
      logic              ident;      // joint out of range: identity pose
      logic [FRAC_W-1:0] frac;
      logic [2:0][31:0]  offset;
      logic [LANES-1:0][31:0] pose_a;
      logic [LANES-1:0][31:0] pose_b;
   } task_type;

   // 20.12 product: 64-bit signed product, arithmetic shift by 12, low 32 bits.
   function automatic logic [31:0] fx_mul(input logic [31:0] a, input logic [31:0] b);
      logic signed [63:0] p;
      p = $signed(a) * $signed(b);
      return p[43:12];
   endfunction

endpackage

[rtl/bcwp_front.sv]
// Front end: takes requests, writes the pose and bone tables, looks up queries
// and reads both frames of the pose memories. Uses bcwp_pkg.
module bcwp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [1:0]            req_op,
   input  logic [10:0]           req_slot,
   input  logic [21:0]           req_frame_position,
   input  logic [31:0]           req_word_a,
   input  logic [31:0]           req_word_b,
   input  logic [31:0]           req_word_c,
   input  logic [31:0]           req_word_d,
   input  logic [7:0]            req_bone_joint,
   input  logic [1:0]            req_bone_kind,
   input  bcwp_pkg::cfg_type     cfg,
   output logic                  task_valid,
   input  logic                  task_ready,
   output bcwp_pkg::task_type    task_data
);

   logic [95:0]  pos_mem [bcwp_pkg::POSE_SLOTS];
   logic [127:0] ori_mem [bcwp_pkg::POSE_SLOTS];

   logic [1:0]   kind_ff   [bcwp_pkg::MAX_BONES];
   logic [7:0]   joint_ff  [bcwp_pkg::MAX_BONES];
   logic [95:0]  offset_ff [bcwp_pkg::MAX_BONES];

   logic [95:0]  pos_rd_ff, pos_a_ff;
   logic [127:0] ori_rd_ff, ori_a_ff;
   logic         ph1_ff;
   logic [bcwp_pkg::POSE_W-1:0] addr_b_ff;
   bcwp_pkg::task_type info_ff, info_in, s2_ff;
   logic         s2_valid_ff;

   logic         accept, is_query, rd_en, bone_in_range;
   logic [bcwp_pkg::BONE_W-1:0] bidx;
   logic [6:0]   nf, next;
   logic [5:0]   nj;
   logic [9:0]   frame_raw;
   logic [bcwp_pkg::FRAME_W-1:0] frame, frame_b;
   logic [bcwp_pkg::JOINT_W-1:0] joint;
   logic [bcwp_pkg::POSE_W-1:0]  addr_a, addr_b, rd_addr;

   assign full     = ph1_ff || (s2_valid_ff && !task_ready);
   assign accept   = push && !full;
   assign is_query = (bcwp_pkg::op_type'(req_op) == bcwp_pkg::OP_QUERY);
   assign bidx     = req_slot[bcwp_pkg::BONE_W-1:0];
   assign bone_in_range = (req_slot < 11'(bcwp_pkg::MAX_BONES));

   always_comb begin
      nf = (cfg.frame_count > 7'(bcwp_pkg::MAX_FRAMES)) ? 7'(bcwp_pkg::MAX_FRAMES)
                                                        : cfg.frame_count;
      nj = (cfg.joint_count > 6'(bcwp_pkg::MAX_JOINTS)) ? 6'(bcwp_pkg::MAX_JOINTS)
                                                        : cfg.joint_count;
      frame_raw = req_frame_position[21:12];
      frame = (frame_raw >= {3'b0, nf}) ? '0 : frame_raw[bcwp_pkg::FRAME_W-1:0];
      next  = 7'(frame) + 7'd1;
      frame_b = (next >= nf) ? '0 : next[bcwp_pkg::FRAME_W-1:0];
      joint  = joint_ff[bidx][bcwp_pkg::JOINT_W-1:0];
      addr_a = {frame, joint};
      addr_b = {frame_b, joint};

      info_in        = '0;
      info_in.found  = bone_in_range && (kind_ff[bidx] != 2'd0);
      info_in.kind   = kind_ff[bidx];
      info_in.ident  = ({2'b0, joint_ff[bidx]} >= {4'b0, nj});
      info_in.frac   = req_frame_position[bcwp_pkg::FRAC_W-1:0];
      info_in.offset = offset_ff[bidx];

      rd_en   = (accept && is_query) || ph1_ff;
      rd_addr = ph1_ff ? addr_b_ff : addr_a;
   end

   // table writes and pose reads
   always_ff @(posedge clock) begin
      if (accept) begin
         unique case (bcwp_pkg::op_type'(req_op))
            bcwp_pkg::OP_LOAD_POS:
               pos_mem[req_slot[bcwp_pkg::POSE_W-1:0]] <= {req_word_c, req_word_b, req_word_a};
            bcwp_pkg::OP_LOAD_ORI:
               ori_mem[req_slot[bcwp_pkg::POSE_W-1:0]] <=
                  {req_word_d, req_word_c, req_word_b, req_word_a};
            bcwp_pkg::OP_LOAD_BONE: begin
               if (bone_in_range) begin
                  joint_ff[bidx]  <= req_bone_joint;
                  offset_ff[bidx] <= {req_word_c, req_word_b, req_word_a};
               end
            end
            bcwp_pkg::OP_QUERY: ;
            default: ;
         endcase
      end
      if (rd_en) begin
         pos_rd_ff <= pos_mem[rd_addr];
         ori_rd_ff <= ori_mem[rd_addr];
      end
      if (ph1_ff) begin
         pos_a_ff <= pos_rd_ff;
         ori_a_ff <= ori_rd_ff;
         s2_ff    <= info_ff;
      end
      if (accept && is_query) begin
         info_ff   <= info_in;
         addr_b_ff <= addr_b;
      end
   end

   // shape kinds clear on reset, so an empty bone reads as "none"
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bcwp_pkg::MAX_BONES; i++) kind_ff[i] <= 2'd0;
      end else if (accept && bcwp_pkg::op_type'(req_op) == bcwp_pkg::OP_LOAD_BONE
                   && bone_in_range) begin
         kind_ff[bidx] <= req_bone_kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph1_ff      <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         ph1_ff <= accept && is_query;
         if (ph1_ff) s2_valid_ff <= 1'b1;
         else if (task_ready) s2_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      task_valid = s2_valid_ff;
      task_data  = s2_ff;
      for (int k = 0; k < 3; k++) begin
         task_data.pose_a[k] = pos_a_ff[32*k +: 32];
         task_data.pose_b[k] = pos_rd_ff[32*k +: 32];
      end
      for (int k = 0; k < 4; k++) begin
         task_data.pose_a[3+k] = ori_a_ff[32*k +: 32];
         task_data.pose_b[3+k] = ori_rd_ff[32*k +: 32];
      end
   end

endmodule

[rtl/bcwp_queue.sv]
// Two-entry queue of looked-up queries between front and back.
// Uses bcwp_pkg for the entry type.
module bcwp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_valid,
   output logic               wr_ready,
   input  bcwp_pkg::task_type wr_data,
   output logic               rd_valid,
   input  logic               rd_take,
   output bcwp_pkg::task_type rd_data
);

   bcwp_pkg::task_type mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_wr, do_rd;

   assign wr_ready = (count_ff != 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_take && rd_valid;

   always_ff @(posedge clock) begin
      if (do_wr) mem_ff[wr_ptr_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_wr) wr_ptr_ff <= !wr_ptr_ff;
         if (do_rd) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(do_wr) - 2'(do_rd);
      end
   end

endmodule

[rtl/bcwp_back.sv]
// Back end: lerp, quaternion rotation, scale and translate, eight register stages
// ending in the result register. Uses bcwp_pkg.
module bcwp_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               task_valid,
   output logic               task_take,
   input  bcwp_pkg::task_type task_data,
   input  bcwp_pkg::cfg_type  cfg,
   output logic               empty,
   input  logic               pop,
   output logic               rsp_found,
   output logic [31:0]        rsp_world_x,
   output logic [31:0]        rsp_world_y,
   output logic [31:0]        rsp_world_z,
   output logic [1:0]         rsp_shape_kind
);

   typedef struct packed {
      logic       found;
      logic [1:0] kind;
      logic       ident;
   } side_type;

   logic        en;
   logic [7:1]  v_ff;
   logic        out_valid_ff;
   side_type    sd_ff [7:1];

   logic [31:0] s1_ff [bcwp_pkg::LANES];
   logic [31:0] d1_ff [bcwp_pkg::LANES];
   logic [31:0] pq2_ff [bcwp_pkg::LANES];
   logic [31:0] pq3_ff [bcwp_pkg::LANES];
   logic [31:0] pq4_ff [bcwp_pkg::LANES];
   logic [31:0] v1_ff [3], v2_ff [3], v3_ff [3], v4_ff [3], v5_ff [3];
   logic [31:0] m3_ff [6];
   logic [31:0] t4_ff [3];
   logic [31:0] n5_ff [9];
   logic [31:0] p5_ff [3];
   logic [31:0] sum6_ff [3];
   logic [31:0] sc7_ff [3];
   logic [31:0] wx_ff, wy_ff, wz_ff;
   logic        found_ff;
   logic [1:0]  kind_ff;

   assign en        = !out_valid_ff || pop;
   assign task_take = en;
   assign empty     = !out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         v_ff         <= {v_ff[6:1], task_valid};
         out_valid_ff <= v_ff[7];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // stage 1: (end - start) * fraction per lane
         sd_ff[1] <= '{task_data.found, task_data.kind, task_data.ident};
         for (int k = 0; k < bcwp_pkg::LANES; k++) begin
            s1_ff[k] <= task_data.pose_a[k];
            d1_ff[k] <= (task_data.pose_b[k] - task_data.pose_a[k])
                        * {20'd0, task_data.frac};
         end
         for (int k = 0; k < 3; k++) v1_ff[k] <= task_data.offset[k];

         // stage 2: finish lerp, or identity pose
         sd_ff[2] <= sd_ff[1];
         for (int k = 0; k < bcwp_pkg::LANES; k++) begin
            if (sd_ff[1].ident)
               pq2_ff[k] <= (k == 3) ? bcwp_pkg::ONE_FX : 32'd0;
            else
               pq2_ff[k] <= s1_ff[k] + {{12{d1_ff[k][31]}}, d1_ff[k][31:12]};
         end
         for (int k = 0; k < 3; k++) v2_ff[k] <= v1_ff[k];

         // stage 3: cross product terms q x v (q1..q3 are lanes 4..6)
         sd_ff[3] <= sd_ff[2];
         m3_ff[0] <= bcwp_pkg::fx_mul(pq2_ff[5], v2_ff[2]);
         m3_ff[1] <= bcwp_pkg::fx_mul(pq2_ff[6], v2_ff[1]);
         m3_ff[2] <= bcwp_pkg::fx_mul(pq2_ff[6], v2_ff[0]);
         m3_ff[3] <= bcwp_pkg::fx_mul(pq2_ff[4], v2_ff[2]);
         m3_ff[4] <= bcwp_pkg::fx_mul(pq2_ff[4], v2_ff[1]);
         m3_ff[5] <= bcwp_pkg::fx_mul(pq2_ff[5], v2_ff[0]);
         for (int k = 0; k < bcwp_pkg::LANES; k++) pq3_ff[k] <= pq2_ff[k];
         for (int k = 0; k < 3; k++) v3_ff[k] <= v2_ff[k];

         // stage 4: t = 2 * (q x v)
         sd_ff[4] <= sd_ff[3];
         t4_ff[0] <= (m3_ff[0] - m3_ff[1]) << 1;
         t4_ff[1] <= (m3_ff[2] - m3_ff[3]) << 1;
         t4_ff[2] <= (m3_ff[4] - m3_ff[5]) << 1;
         for (int k = 0; k < bcwp_pkg::LANES; k++) pq4_ff[k] <= pq3_ff[k];
         for (int k = 0; k < 3; k++) v4_ff[k] <= v3_ff[k];

         // stage 5: w * t and q x t
         sd_ff[5] <= sd_ff[4];
         n5_ff[0] <= bcwp_pkg::fx_mul(pq4_ff[3], t4_ff[0]);
         n5_ff[1] <= bcwp_pkg::fx_mul(pq4_ff[5], t4_ff[2]);
         n5_ff[2] <= bcwp_pkg::fx_mul(pq4_ff[6], t4_ff[1]);
         n5_ff[3] <= bcwp_pkg::fx_mul(pq4_ff[3], t4_ff[1]);
         n5_ff[4] <= bcwp_pkg::fx_mul(pq4_ff[6], t4_ff[0]);
         n5_ff[5] <= bcwp_pkg::fx_mul(pq4_ff[4], t4_ff[2]);
         n5_ff[6] <= bcwp_pkg::fx_mul(pq4_ff[3], t4_ff[2]);
         n5_ff[7] <= bcwp_pkg::fx_mul(pq4_ff[4], t4_ff[1]);
         n5_ff[8] <= bcwp_pkg::fx_mul(pq4_ff[5], t4_ff[0]);
         for (int k = 0; k < 3; k++) begin
            p5_ff[k] <= pq4_ff[k];
            v5_ff[k] <= v4_ff[k];
         end

         // stage 6: rotated offset plus joint position
         sd_ff[6] <= sd_ff[5];
         sum6_ff[0] <= p5_ff[0] + v5_ff[0] + n5_ff[0] + (n5_ff[1] - n5_ff[2]);
         sum6_ff[1] <= p5_ff[1] + v5_ff[1] + n5_ff[3] + (n5_ff[4] - n5_ff[5]);
         sum6_ff[2] <= p5_ff[2] + v5_ff[2] + n5_ff[6] + (n5_ff[7] - n5_ff[8]);

         // stage 7: per-axis scale
         sd_ff[7] <= sd_ff[6];
         for (int k = 0; k < 3; k++)
            sc7_ff[k] <= bcwp_pkg::fx_mul(sum6_ff[k], cfg.scale[k]);

         // result register: translate; a miss reports all zero
         found_ff <= sd_ff[7].found;
         kind_ff  <= sd_ff[7].found ? sd_ff[7].kind : 2'd0;
         wx_ff    <= sd_ff[7].found ? cfg.model[0] + sc7_ff[0] : 32'd0;
         wy_ff    <= sd_ff[7].found ? cfg.model[1] + sc7_ff[1] : 32'd0;
         wz_ff    <= sd_ff[7].found ? cfg.model[2] + sc7_ff[2] : 32'd0;
      end
   end

   assign rsp_found      = found_ff;
   assign rsp_world_x    = wx_ff;
   assign rsp_world_y    = wy_ff;
   assign rsp_world_z    = wz_ff;
   assign rsp_shape_kind = kind_ff;

endmodule

[rtl/bone_collider_world_position_unit.sv]
// Top level of the bone collider world position unit: config registers, front,
// queue and back. Depends on bcwp_pkg, bcwp_front, bcwp_queue and bcwp_back.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+------------------------------------
//   request  | in        | push / full        | req_op, req_slot, req_frame_position,
//            |           |                    | req_word_a..d, req_bone_joint/kind
//   response | out       | empty / pop        | rsp_found, rsp_world_x/y/z,
//            |           |                    | rsp_shape_kind
//   csr      | in        | csr_valid/csr_ready| csr_index, csr_wdata
//
// A load is taken whenever full is low. A query makes two pose memory reads (frame,
// then next frame), and the front holds full high during the second read, so no
// request is taken during it. A query's result then passes the queue and the back.
// Reset is synchronous; pose tables are not cleared, bone shape kinds read as none.
// The back stalls as a whole only while a result waits to be popped; a two-entry
// queue lets the front keep taking requests meanwhile, until the queue fills.
module bone_collider_world_position_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_op,
   input  logic [10:0] req_slot,
   input  logic [21:0] req_frame_position,
   input  logic [31:0] req_word_a,
   input  logic [31:0] req_word_b,
   input  logic [31:0] req_word_c,
   input  logic [31:0] req_word_d,
   input  logic [7:0]  req_bone_joint,
   input  logic [1:0]  req_bone_kind,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_found,
   output logic [31:0] rsp_world_x,
   output logic [31:0] rsp_world_y,
   output logic [31:0] rsp_world_z,
   output logic [1:0]  rsp_shape_kind,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   bcwp_pkg::cfg_type  cfg_ff;
   bcwp_pkg::task_type fq_data, qb_data;
   logic               fq_valid, fq_ready, qb_valid, qb_take;

   // the user must change config only while idle; the block does not enforce it, so it is written without interlock
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_count <= 7'd1;
         cfg_ff.joint_count <= 6'd1;
         cfg_ff.model       <= '0;
         cfg_ff.scale       <= {3{bcwp_pkg::ONE_FX}};
      end else if (csr_valid && csr_ready) begin
         unique case (bcwp_pkg::csr_idx_type'(csr_index))
            bcwp_pkg::CSR_FRAME_COUNT: cfg_ff.frame_count <= csr_wdata[6:0];
            bcwp_pkg::CSR_JOINT_COUNT: cfg_ff.joint_count <= csr_wdata[5:0];
            bcwp_pkg::CSR_MODEL_X:     cfg_ff.model[0]    <= csr_wdata;
            bcwp_pkg::CSR_MODEL_Y:     cfg_ff.model[1]    <= csr_wdata;
            bcwp_pkg::CSR_MODEL_Z:     cfg_ff.model[2]    <= csr_wdata;
            bcwp_pkg::CSR_SCALE_X:     cfg_ff.scale[0]    <= csr_wdata;
            bcwp_pkg::CSR_SCALE_Y:     cfg_ff.scale[1]    <= csr_wdata;
            bcwp_pkg::CSR_SCALE_Z:     cfg_ff.scale[2]    <= csr_wdata;
            default: ;
         endcase
      end
   end

   bcwp_front u_front (
      .clock, .reset, .push, .full,
      .req_op, .req_slot, .req_frame_position,
      .req_word_a, .req_word_b, .req_word_c, .req_word_d,
      .req_bone_joint, .req_bone_kind,
      .cfg        (cfg_ff),
      .task_valid (fq_valid),
      .task_ready (fq_ready),
      .task_data  (fq_data)
   );

   bcwp_queue u_queue (
      .clock, .reset,
      .wr_valid (fq_valid),
      .wr_ready (fq_ready),
      .wr_data  (fq_data),
      .rd_valid (qb_valid),
      .rd_take  (qb_take),
      .rd_data  (qb_data)
   );

   bcwp_back u_back (
      .clock, .reset,
      .task_valid (qb_valid),
      .task_take  (qb_take),
      .task_data  (qb_data),
      .cfg        (cfg_ff),
      .empty, .pop,
      .rsp_found, .rsp_world_x, .rsp_world_y, .rsp_world_z, .rsp_shape_kind
   );

endmodule

[rtl/bcwp_checker.sv]
// Port-level checks on the response side of the unit, bound to the top level.
// Depends only on the top level's ports.
module bcwp_checker (
   input logic        clock,
   input logic        reset,
   input logic        empty,
   input logic        pop,
   input logic        rsp_found,
   input logic [31:0] rsp_world_x,
   input logic [31:0] rsp_world_y,
   input logic [31:0] rsp_world_z,
   input logic [1:0]  rsp_shape_kind
);

   a_empty_after_reset: assert property (@(posedge clock) reset |=> empty)
      else $error("response present right after reset");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_world_x) && $stable(rsp_found)))
      else $error("stalled response changed");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_found) |-> (rsp_world_x == 32'd0 && rsp_world_y == 32'd0
                                  && rsp_world_z == 32'd0 && rsp_shape_kind == 2'd0))
      else $error("miss response not all zero");

   a_hit_kind: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_found) |-> (rsp_shape_kind != 2'd0))
      else $error("hit response with shape kind none");

endmodule

bind bone_collider_world_position_unit bcwp_checker u_bcwp_checker (
   .clock, .reset, .empty, .pop,
   .rsp_found, .rsp_world_x, .rsp_world_y, .rsp_world_z, .rsp_shape_kind
);
